// ===== rtl/vip_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vip_pkg: shared definitions for the variable-integral pid step
// widths, fixed-point formats, thresholds and register indexes
// ----------------------------------------------------------------------------
package vip_pkg;

    // value format: signed q15.8
    localparam int VALUE_W     = 24;
    localparam int FRAC_BITS   = 8;
    // integral accumulator width
    localparam int SUM_W       = 40;
    // gains: unsigned q4.12
    localparam int GAIN_W      = 16;
    localparam int GAIN_FRAC   = 12;
    // integral weight: unsigned q1.16, one is 2^16
    localparam int WEIGHT_FRAC = 16;
    localparam int WEIGHT_W    = WEIGHT_FRAC + 1;

    // weight band edges on |e|
    localparam int HI_TH = 200 << FRAC_BITS;
    localparam int LO_TH = 180 << FRAC_BITS;

    // shared multiplier operand and product widths
    localparam int MUL_A_W = 32;
    localparam int MUL_B_W = VALUE_W + 1;
    localparam int PROD_W  = MUL_A_W + MUL_B_W;

    // floor(y / 5) ~ (y * RECIP5) >> RECIP5_SH, over by at most one
    localparam int RECIP5    = 52429;
    localparam int RECIP5_SH = 18;

    // configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_KP = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_KI = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_KD = 2'd2;

    // gain reset values
    localparam logic [GAIN_W-1:0] KP_RESET = 16'd1638;
    localparam logic [GAIN_W-1:0] KI_RESET = 16'd819;
    localparam logic [GAIN_W-1:0] KD_RESET = 16'd819;

endpackage : vip_pkg
`default_nettype wire

// ===== rtl/vip_mul.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vip_mul: shared unsigned multiplier
// one 32x25 product per cycle, registered at the output
// ----------------------------------------------------------------------------
module vip_mul
    import vip_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic [MUL_A_W-1:0] i_a,
    input  wire logic [MUL_B_W-1:0] i_b,
    output logic      [PROD_W-1:0]  o_prod
);

    logic [PROD_W-1:0] r_prod;

    // product register, payload only
    always_ff @(posedge i_clk) begin
        r_prod <= PROD_W'(i_a) * PROD_W'(i_b);
    end

    assign o_prod = r_prod;

endmodule : vip_mul
`default_nettype wire

// ===== rtl/variable_integral_pid_step.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// variable_integral_pid_step: positional pid step with variable integral weight
// takes a setpoint, returns the clipped drive value and a saturation flag
// ----------------------------------------------------------------------------
// Each setpoint accepted on the slave stream produces one drive value on the
// master stream once the sequencer has stepped from S_ERR through S_OUT; the
// block takes no new setpoint until the last has left S_OUT. The pace is set
// by the one shared 32x25 multiplier, which the sequencer uses six times per
// item (P term, weight division by reciprocal, D term, Ki times weight, and
// the two halves of the integral product). A finished result waits in the
// output register while the block goes back to idle, so the next setpoint can
// be taken before the result is read. Gains may be written through the config
// port only while no item is in flight.
module variable_integral_pid_step
    import vip_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    // slave stream
    input  wire logic                 i_s_axis_tvalid,
    output logic                      o_s_axis_tready,
    input  wire logic [VALUE_W-1:0]   i_s_axis_tdata,   // [23:0] setpoint
    // master stream
    output logic                      o_m_axis_tvalid,
    input  wire logic                 i_m_axis_tready,
    output logic      [VALUE_W-1:0]   o_m_axis_tdata,   // [23:0] drive_value
    output logic                      o_m_axis_tuser,   // [0] saturated
    // configuration write port
    input  wire logic                 i_cfg_wen,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [GAIN_W-1:0]    i_cfg_wdata
);

    typedef enum logic [3:0] {
        S_IDLE, S_ERR, S_INT, S_DIV, S_WFIX, S_KI, S_ML, S_MH, S_SUM, S_OUT
    } t_state;

    localparam int TP_W   = VALUE_W + GAIN_W - GAIN_FRAC;      // 28
    localparam int TD_W   = VALUE_W + 1 + GAIN_W - GAIN_FRAC;  // 29
    localparam int TI_W   = 34;                                // capped at 2^33
    localparam int U_W    = 36;
    localparam int Y_W    = 19;
    localparam int HALF_W = SUM_W / 2;
    localparam int IP_W   = MUL_A_W + HALF_W;                  // 52
    localparam int ACC_W  = IP_W + 1 - HALF_W;                 // 33
    localparam int HI_W   = IP_W + 1;                          // 53
    localparam int ISH    = GAIN_FRAC + WEIGHT_FRAC - HALF_W;  // 8

    t_state r_state;

    // gains
    logic [GAIN_W-1:0] r_kp, r_ki, r_kd;
    // controller state
    logic [VALUE_W-1:0] r_act, r_prev;
    logic [SUM_W-1:0]   r_sum;
    // per-item working registers
    logic [VALUE_W-1:0]  r_sp, r_err, r_ae;
    logic [VALUE_W:0]    r_dmag;
    logic                r_dneg;
    logic                r_sat;
    logic [WEIGHT_W-1:0] r_w;
    logic                r_wpart;
    logic [Y_W-1:0]      r_y;
    logic [SUM_W-1:0]    r_smag;
    logic [TP_W-1:0]     r_tp;
    logic [TD_W-1:0]     r_td;
    logic [MUL_A_W-1:0]  r_k;
    logic [ACC_W-1:0]    r_acc;
    logic [TI_W-1:0]     r_ti;
    // output register
    logic                r_out_valid;
    logic [VALUE_W-1:0]  r_out_drive;
    logic                r_out_sat;

    // shared multiplier
    logic [MUL_A_W-1:0] mul_a;
    logic [MUL_B_W-1:0] mul_b;
    logic [PROD_W-1:0]  prod;

    vip_mul u_mul (
        .i_clk  (i_clk),
        .i_a    (mul_a),
        .i_b    (mul_b),
        .o_prod (prod)
    );

    // multiplier operand select per step
    always_comb begin
        case (r_state)
            S_INT:   begin
                mul_a = MUL_A_W'(r_kp);
                mul_b = MUL_B_W'(r_ae);
            end
            S_DIV:   begin
                mul_a = MUL_A_W'(RECIP5);
                mul_b = MUL_B_W'(r_y);
            end
            S_WFIX:  begin
                mul_a = MUL_A_W'(r_kd);
                mul_b = r_dmag;
            end
            S_KI:    begin
                mul_a = MUL_A_W'(r_ki);
                mul_b = MUL_B_W'(r_w);
            end
            S_ML:    begin
                mul_a = prod[MUL_A_W-1:0];
                mul_b = MUL_B_W'(r_smag[HALF_W-1:0]);
            end
            S_MH:    begin
                mul_a = r_k;
                mul_b = MUL_B_W'(r_smag[SUM_W-1:HALF_W]);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // error: setpoint minus last output, clipped to the value range
    logic [VALUE_W:0]   n_diff;
    logic               n_eovf;
    logic [VALUE_W-1:0] n_err, n_ae;
    always_comb begin
        n_diff = {r_sp[VALUE_W-1], r_sp} - {r_act[VALUE_W-1], r_act};
        n_eovf = n_diff[VALUE_W] != n_diff[VALUE_W-1];
        if (n_eovf) begin
            n_err = n_diff[VALUE_W] ? {1'b1, {(VALUE_W-1){1'b0}}}
                                    : {1'b0, {(VALUE_W-1){1'b1}}};
        end else begin
            n_err = n_diff[VALUE_W-1:0];
        end
        n_ae = n_err[VALUE_W-1] ? (~n_err + 1'b1) : n_err;
    end

    // integral update, error delta and weight band
    logic [SUM_W:0]     n_sum_wide;
    logic               n_sovf;
    logic [SUM_W-1:0]   n_sum;
    logic               n_frozen;
    logic [VALUE_W:0]   n_de;
    logic [VALUE_W-1:0] n_d;
    always_comb begin
        n_sum_wide = {r_sum[SUM_W-1], r_sum}
                   + {{(SUM_W-VALUE_W+1){r_err[VALUE_W-1]}}, r_err};
        n_sovf     = n_sum_wide[SUM_W] != n_sum_wide[SUM_W-1];
        if (n_sovf) begin
            n_sum = n_sum_wide[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}}
                                      : {1'b0, {(SUM_W-1){1'b1}}};
        end else begin
            n_sum = n_sum_wide[SUM_W-1:0];
        end
        n_frozen = r_ae > VALUE_W'(HI_TH);
        n_de     = {r_err[VALUE_W-1], r_err} - {r_prev[VALUE_W-1], r_prev};
        n_d      = VALUE_W'(HI_TH) - r_ae;
    end

    // weight = floor((64*d + 2) / 5), reciprocal estimate with one correction
    logic [WEIGHT_W-1:0] n_q;
    logic [Y_W+1:0]      n_rem;
    always_comb begin
        n_q   = prod[RECIP5_SH +: WEIGHT_W];
        n_rem = (Y_W+2)'(r_y) - ((Y_W+2)'(n_q) << 2) - (Y_W+2)'(n_q);
    end

    // rounded p and d terms
    logic [VALUE_W+GAIN_W-1:0]   n_tp_full;
    logic [VALUE_W+GAIN_W:0]     n_td_full;
    always_comb begin
        n_tp_full = prod[VALUE_W+GAIN_W-1:0]
                  + (VALUE_W+GAIN_W)'(1 << (GAIN_FRAC-1));
        n_td_full = prod[VALUE_W+GAIN_W:0]
                  + (VALUE_W+GAIN_W+1)'(1 << (GAIN_FRAC-1));
    end

    // integral product assembly, rounding bias folded into the low half
    logic [IP_W:0] n_acc_full;
    logic [HI_W-1:0] n_hi;
    logic [TI_W-1:0] n_ti;
    always_comb begin
        n_acc_full = {1'b0, prod[IP_W-1:0]}
                   + (IP_W+1)'(1 << (GAIN_FRAC + WEIGHT_FRAC - 1));
        n_hi = HI_W'(r_acc) + {1'b0, prod[IP_W-1:0]};
        if (|n_hi[HI_W-1:ISH+TI_W-1]) begin
            n_ti = {1'b1, {(TI_W-1){1'b0}}};
        end else begin
            n_ti = {1'b0, n_hi[ISH +: TI_W-1]};
        end
    end

    // signed sum of the three terms and output clip
    logic signed [U_W-1:0] n_sp, n_si, n_sd, n_u;
    logic                  n_uovf;
    logic [VALUE_W-1:0]    n_drive;
    always_comb begin
        n_sp = r_err[VALUE_W-1] ? -$signed(U_W'(r_tp)) : $signed(U_W'(r_tp));
        n_si = r_sum[SUM_W-1]   ? -$signed(U_W'(r_ti)) : $signed(U_W'(r_ti));
        n_sd = r_dneg           ? -$signed(U_W'(r_td)) : $signed(U_W'(r_td));
        n_u  = n_sp + n_si + n_sd;
        n_uovf = !((&n_u[U_W-1:VALUE_W-1]) || !(|n_u[U_W-1:VALUE_W-1]));
        if (n_uovf) begin
            n_drive = n_u[U_W-1] ? {1'b1, {(VALUE_W-1){1'b0}}}
                                 : {1'b0, {(VALUE_W-1){1'b1}}};
        end else begin
            n_drive = n_u[VALUE_W-1:0];
        end
    end

    logic n_in_xfer, n_out_free, n_out_load;
    assign n_in_xfer  = i_s_axis_tvalid && (r_state == S_IDLE);
    assign n_out_free = !r_out_valid || i_m_axis_tready;
    assign n_out_load = (r_state == S_OUT) && n_out_free;

    // sequencer, controller state and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_kp        <= KP_RESET;
            r_ki        <= KI_RESET;
            r_kd        <= KD_RESET;
            r_act       <= '0;
            r_prev      <= '0;
            r_sum       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            // gain writes
            if (i_cfg_wen) begin
                case (i_cfg_index)
                    CFG_KP:  r_kp <= i_cfg_wdata;
                    CFG_KI:  r_ki <= i_cfg_wdata;
                    CFG_KD:  r_kd <= i_cfg_wdata;
                    default: ;
                endcase
            end

            // output valid: set by a finished item, cleared by a transfer
            if (n_out_load) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (n_in_xfer) begin
                        r_sp    <= i_s_axis_tdata;
                        r_state <= S_ERR;
                    end
                end
                S_ERR: begin
                    r_err   <= n_err;
                    r_ae    <= n_ae;
                    r_sat   <= n_eovf;
                    r_state <= S_INT;
                end
                S_INT: begin
                    if (!n_frozen) begin
                        r_sum <= n_sum;
                        if (n_sovf) begin
                            r_sat <= 1'b1;
                        end
                    end
                    r_w     <= n_frozen ? '0 : {1'b1, {WEIGHT_FRAC{1'b0}}};
                    r_wpart <= !n_frozen && (r_ae >= VALUE_W'(LO_TH));
                    r_y     <= {n_d[Y_W-7:0], 6'd2};
                    r_dneg  <= n_de[VALUE_W];
                    r_dmag  <= n_de[VALUE_W] ? (~n_de + 1'b1) : n_de;
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    r_tp    <= n_tp_full[VALUE_W+GAIN_W-1:GAIN_FRAC];
                    r_smag  <= r_sum[SUM_W-1] ? (~r_sum + 1'b1) : r_sum;
                    r_state <= S_WFIX;
                end
                S_WFIX: begin
                    if (r_wpart) begin
                        r_w <= n_rem[Y_W+1] ? (n_q - 1'b1) : n_q;
                    end
                    r_state <= S_KI;
                end
                S_KI: begin
                    r_td    <= n_td_full[VALUE_W+GAIN_W:GAIN_FRAC];
                    r_state <= S_ML;
                end
                S_ML: begin
                    r_k     <= prod[MUL_A_W-1:0];
                    r_state <= S_MH;
                end
                S_MH: begin
                    r_acc   <= n_acc_full[IP_W:HALF_W];
                    r_state <= S_SUM;
                end
                S_SUM: begin
                    r_ti    <= n_ti;
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (n_out_free) begin
                        r_out_drive <= n_drive;
                        r_out_sat   <= r_sat || n_uovf;
                        r_act       <= n_drive;
                        r_prev      <= r_err;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_drive;
    assign o_m_axis_tuser  = r_out_sat;

endmodule : variable_integral_pid_step
`default_nettype wire
